// File: design/ip_address_text_parser_top_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef IP_ADDRESS_TEXT_PARSER_TOP_MACROS_SVH
`define IP_ADDRESS_TEXT_PARSER_TOP_MACROS_SVH

// Checked at every clock edge, reset included.
`define IPATP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// Checked only while reset is low.
`define IPATP_ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// File: design/ipatp_pkg.sv
`default_nettype none

package ipatp_pkg;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic        valid_res;
      logic        is_ipv4;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } rsp_item_type;

   typedef enum logic [2:0] {
      PH_PRE,
      PH_NUM,
      PH_POST,
      PH_TAIL,
      PH_OK,
      PH_FAIL
   } phase_type;

   localparam int QUARTETS = 8;

   localparam logic [7:0]  CHAR_SPACE  = 8'h20;
   localparam logic [7:0]  CHAR_DOT    = 8'h2e;
   localparam logic [7:0]  CHAR_COLON  = 8'h3a;
   localparam logic [7:0]  CHAR_LBRACK = 8'h5b;
   localparam logic [7:0]  CHAR_RBRACK = 8'h5d;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [11:0] BYTE_MAX    = 12'd255;
   localparam logic [31:0] V4_MAPPED   = 32'h0000ffff;

   // Returns {is_hex_digit, nibble value}.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'h00;
         case (c) inside
            [8'h30:8'h39]: begin
               diff = c - 8'h30;
               hex_decode = {1'b1, diff[3:0]};
            end
            [8'h41:8'h46]: begin
               diff = c - 8'h37;
               hex_decode = {1'b1, diff[3:0]};
            end
            [8'h61:8'h66]: begin
               diff = c - 8'h57;
               hex_decode = {1'b1, diff[3:0]};
            end
            default: begin
               hex_decode = 5'b0_0000;
            end
         endcase
      end
   endfunction

endpackage

`default_nettype wire

// File: design/ipatp_if.sv
`default_nettype none

interface ipatp_req_if;
   import ipatp_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface ipatp_rsp_if;
   import ipatp_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: design/ip_address_text_parser_top.sv
// Throughput is one character item per cycle; only an item that carries last can wait, and
// only while the previous result is still held on the output and not taken.
// The result is registered when the item that carries last leaves the input register.
// All parser state is updated in one pass of logic between the two registers.
// Reset is synchronous and active high; it empties both registers and returns the
// dotted and hex parsers to their start state.
`default_nettype none
`include "ip_address_text_parser_top_macros.svh"

module ip_address_text_parser_top (
   input wire logic   clock,
   input wire logic   reset,
   ipatp_req_if.sink  req_chan,
   ipatp_rsp_if.source rsp_chan
);
   import ipatp_pkg::*;

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   logic out_free;
   logic s1_adv;
   logic s1_done;

   logic seen_dot_ff, seen_colon_ff, seen_nonspace_ff, bracketed_ff;
   logic seen_dot_in, seen_colon_in, seen_nonspace_in, bracketed_in;

   phase_type   dotted_phase_ff, dotted_phase_in;
   logic [1:0]  dotted_count_ff, dotted_count_in;
   logic [7:0]  dotted_value_ff, dotted_value_in;
   logic [31:0] dotted_addr_ff, dotted_addr_in;

   phase_type   hex_phase_ff, hex_phase_in;
   logic [2:0]  hex_count_ff, hex_count_in;
   logic [2:0]  hex_digits_ff, hex_digits_in;
   logic [15:0] hex_value_ff, hex_value_in;
   logic [15:0] quartet_ff [QUARTETS];
   logic [15:0] quartet_view [QUARTETS];

   logic        quartet_we;
   logic [7:0]  c;
   logic        is_digit;
   logic [7:0]  dec_diff;
   logic [4:0]  hex_dec;
   logic [11:0] dec_next;
   logic        d_done, h_done;
   phase_type   d_final, h_final;
   logic [31:0] d_addr_final;
   logic        d_ok, h_ok;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && (!s1_item_ff.last || out_free);
   assign s1_done        = s1_adv && s1_item_ff.last;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.item  = rsp_item_ff;

   always_comb begin
      c        = s1_item_ff.ch;
      is_digit = (c >= CHAR_ZERO) && (c <= 8'h39);
      dec_diff = c - CHAR_ZERO;
      hex_dec  = hex_decode(c);
      dec_next = ({4'h0, dotted_value_ff} << 3) + ({4'h0, dotted_value_ff} << 1)
               + {8'h00, dec_diff[3:0]};

      seen_dot_in      = seen_dot_ff || (c == CHAR_DOT);
      seen_colon_in    = seen_colon_ff || (c == CHAR_COLON);
      seen_nonspace_in = seen_nonspace_ff || (c != CHAR_SPACE);

      // Dotted parser.
      dotted_phase_in = dotted_phase_ff;
      dotted_count_in = dotted_count_ff;
      dotted_value_in = dotted_value_ff;
      dotted_addr_in  = dotted_addr_ff;
      d_done          = 1'b0;
      if (dotted_phase_ff == PH_NUM) begin
         if (is_digit) begin
            d_done = 1'b1;
            if (dec_next > BYTE_MAX) begin
               dotted_phase_in = PH_FAIL;
            end else begin
               dotted_value_in = dec_next[7:0];
            end
         end else begin
            dotted_addr_in  = {dotted_addr_ff[23:0], dotted_value_ff};
            dotted_phase_in = (dotted_count_ff == 2'd3) ? PH_TAIL : PH_POST;
         end
      end
      if (!d_done && c != CHAR_SPACE) begin
         case (dotted_phase_in)
            PH_PRE: begin
               if (is_digit) begin
                  dotted_phase_in = PH_NUM;
                  dotted_value_in = {4'h0, dec_diff[3:0]};
               end else begin
                  dotted_phase_in = PH_FAIL;
               end
            end
            PH_POST: begin
               if (c == CHAR_DOT) begin
                  dotted_phase_in = PH_PRE;
                  dotted_count_in = dotted_count_ff + 2'd1;
               end else begin
                  dotted_phase_in = PH_FAIL;
               end
            end
            PH_TAIL: begin
               dotted_phase_in = (c == CHAR_COLON) ? PH_OK : PH_FAIL;
            end
            default: begin
            end
         endcase
      end

      d_final      = dotted_phase_in;
      d_addr_final = dotted_addr_in;
      if (dotted_phase_in == PH_NUM) begin
         d_addr_final = {dotted_addr_in[23:0], dotted_value_in};
         d_final      = (dotted_count_in == 2'd3) ? PH_TAIL : PH_POST;
      end
      d_ok = (d_final == PH_OK) || (d_final == PH_TAIL);

      // Hex parser.
      hex_phase_in  = hex_phase_ff;
      hex_count_in  = hex_count_ff;
      hex_digits_in = hex_digits_ff;
      hex_value_in  = hex_value_ff;
      bracketed_in  = bracketed_ff;
      quartet_we    = 1'b0;
      h_done        = 1'b0;
      if (hex_phase_ff == PH_NUM) begin
         if (hex_dec[4]) begin
            h_done = 1'b1;
            if (hex_digits_ff >= 3'd4) begin
               hex_phase_in = PH_FAIL;
            end else begin
               hex_digits_in = hex_digits_ff + 3'd1;
               hex_value_in  = {hex_value_ff[11:0], hex_dec[3:0]};
            end
         end else begin
            quartet_we   = 1'b1;
            hex_phase_in = (hex_count_ff == 3'd7) ? PH_TAIL : PH_POST;
         end
      end
      if (!h_done && c != CHAR_SPACE) begin
         case (hex_phase_in)
            PH_PRE: begin
               if (c == CHAR_LBRACK && !seen_nonspace_ff) begin
                  bracketed_in = 1'b1;
               end else if (hex_dec[4]) begin
                  hex_phase_in  = PH_NUM;
                  hex_digits_in = 3'd1;
                  hex_value_in  = {12'h000, hex_dec[3:0]};
               end else begin
                  hex_phase_in = PH_FAIL;
               end
            end
            PH_POST: begin
               if (c == CHAR_COLON) begin
                  hex_phase_in = PH_PRE;
                  hex_count_in = hex_count_ff + 3'd1;
               end else begin
                  hex_phase_in = PH_FAIL;
               end
            end
            PH_TAIL: begin
               hex_phase_in = (c == CHAR_RBRACK && bracketed_ff) ? PH_OK : PH_FAIL;
            end
            default: begin
            end
         endcase
      end

      h_final = hex_phase_in;
      if (hex_phase_in == PH_NUM) begin
         quartet_we = 1'b1;
         h_final    = (hex_count_in == 3'd7) ? PH_TAIL : PH_POST;
      end
      h_ok = (h_final == PH_OK) || (h_final == PH_TAIL);

      for (int i = 0; i < QUARTETS; i++) begin
         quartet_view[i] = (quartet_we && hex_count_ff == 3'(i)) ? hex_value_in
                                                                : quartet_ff[i];
      end

      rsp_item_in = '0;
      if (seen_dot_in) begin
         if (d_ok) begin
            rsp_item_in.valid_res = 1'b1;
            rsp_item_in.is_ipv4   = 1'b1;
            rsp_item_in.addr_low  = {V4_MAPPED, d_addr_final};
         end
      end else if (seen_colon_in && h_ok) begin
         rsp_item_in.valid_res = 1'b1;
         rsp_item_in.addr_high = {quartet_view[0], quartet_view[1],
                                  quartet_view[2], quartet_view[3]};
         rsp_item_in.addr_low  = {quartet_view[4], quartet_view[5],
                                  quartet_view[6], quartet_view[7]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s1_item_ff <= req_chan.item;
      end

      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_done) begin
         rsp_item_ff <= rsp_item_in;
      end

      if (reset || s1_done) begin
         seen_dot_ff      <= 1'b0;
         seen_colon_ff    <= 1'b0;
         seen_nonspace_ff <= 1'b0;
         bracketed_ff     <= 1'b0;
         dotted_phase_ff  <= PH_PRE;
         dotted_count_ff  <= 2'd0;
         hex_phase_ff     <= PH_PRE;
         hex_count_ff     <= 3'd0;
         hex_digits_ff    <= 3'd0;
      end else if (s1_adv) begin
         seen_dot_ff      <= seen_dot_in;
         seen_colon_ff    <= seen_colon_in;
         seen_nonspace_ff <= seen_nonspace_in;
         bracketed_ff     <= bracketed_in;
         dotted_phase_ff  <= dotted_phase_in;
         dotted_count_ff  <= dotted_count_in;
         hex_phase_ff     <= hex_phase_in;
         hex_count_ff     <= hex_count_in;
         hex_digits_ff    <= hex_digits_in;
      end

      if (s1_adv) begin
         dotted_value_ff <= dotted_value_in;
         dotted_addr_ff  <= dotted_addr_in;
         hex_value_ff    <= hex_value_in;
         if (quartet_we) begin
            quartet_ff[hex_count_ff] <= hex_value_in;
         end
      end
   end

   `IPATP_ASSERT_ALWAYS(a_invalid_is_zero,
      rsp_valid_ff && !rsp_item_ff.valid_res |-> !rsp_item_ff.is_ipv4 &&
      rsp_item_ff.addr_high == 64'h0 && rsp_item_ff.addr_low == 64'h0,
      "An invalid result carries a nonzero field.")
   `IPATP_ASSERT_ALWAYS(a_ipv4_mapped,
      rsp_valid_ff && rsp_item_ff.is_ipv4 |-> rsp_item_ff.valid_res &&
      rsp_item_ff.addr_high == 64'h0 && rsp_item_ff.addr_low[63:32] == V4_MAPPED,
      "An IPv4 result is not in the mapped form.")
   `IPATP_ASSERT_SYNC(a_state_cleared_after_last,
      s1_done |=> dotted_phase_ff == PH_PRE && hex_phase_ff == PH_PRE &&
      hex_count_ff == 3'd0 && !seen_dot_ff && !seen_colon_ff && !bracketed_ff,
      "Parser state was not cleared after the last item of a string.")
   `IPATP_ASSERT_SYNC(a_hex_digit_limit,
      hex_digits_ff <= 3'd4,
      "Hex digit count ran past four.")
   `IPATP_ASSERT_SYNC(a_result_after_last,
      $rose(rsp_valid_ff) |-> $past(s1_done),
      "A result appeared without a last item.")

endmodule

`default_nettype wire

// File: verif/ip_address_text_parser_top_tb.sv
module ip_address_text_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ipatp_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_CHARS = 920;
   localparam int MIN_LINES    = 60;

   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_G = 8'h67;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_MOSTLY
   } rx_mode_type;

   logic clock;
   logic reset;

   ipatp_req_if req_chan ();
   ipatp_rsp_if rsp_chan ();

   ip_address_text_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   req_item_type pending_chars [$];
   rsp_item_type expected_addrs [$];
   logic [7:0]   text_buf [$];

   int mismatches;
   int cycle_count;
   int burst_left;
   int gap_left;
   int rx_left;
   rx_mode_type rx_mode;
   rsp_item_type want_addr;

   logic        saw_dot;
   logic        saw_colon;
   logic        saw_text;
   logic        in_brackets;
   phase_type   v4_phase;
   logic [2:0]  v4_index;
   logic [7:0]  v4_byte;
   logic [31:0] v4_word;
   phase_type   v6_phase;
   logic [2:0]  v6_index;
   logic [2:0]  v6_ndigits;
   logic [15:0] v6_group;
   logic [15:0] v6_groups [QUARTETS];

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         return {1'b1, 4'(c - CHAR_ZERO)};
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         return {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         return {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
      end
      return 5'b0_0000;
   endfunction

   task automatic clear_parsers();
      saw_dot     = 1'b0;
      saw_colon   = 1'b0;
      saw_text    = 1'b0;
      in_brackets = 1'b0;
      v4_phase    = PH_PRE;
      v4_index    = 3'd0;
      v4_byte     = 8'd0;
      v4_word     = 32'd0;
      v6_phase    = PH_PRE;
      v6_index    = 3'd0;
      v6_ndigits  = 3'd0;
      v6_group    = 16'd0;
      foreach (v6_groups[i]) begin
         v6_groups[i] = 16'd0;
      end
   endtask

   task automatic close_dotted_byte();
      v4_word  = {v4_word[23:0], v4_byte};
      v4_phase = (v4_index >= 3'd3) ? PH_TAIL : PH_POST;
   endtask

   task automatic close_hex_quartet();
      v6_groups[v6_index] = v6_group;
      v6_phase = (v6_index >= 3'd7) ? PH_TAIL : PH_POST;
   endtask

   task automatic step_dotted(input logic [7:0] c);
      logic        is_dec;
      logic [11:0] acc;
      is_dec = (c >= CHAR_ZERO && c <= CHAR_NINE);
      if (v4_phase == PH_NUM && is_dec) begin
         acc = 12'(v4_byte) * 12'd10 + 12'(c) - 12'(CHAR_ZERO);
         if (acc > BYTE_MAX) begin
            v4_phase = PH_FAIL;
         end else begin
            v4_byte = acc[7:0];
         end
      end else begin
         if (v4_phase == PH_NUM) begin
            close_dotted_byte();
         end
         case (v4_phase)
            PH_PRE: begin
               if (is_dec) begin
                  v4_phase = PH_NUM;
                  v4_byte  = c - CHAR_ZERO;
               end else if (c != CHAR_SPACE) begin
                  v4_phase = PH_FAIL;
               end
            end
            PH_POST: begin
               if (c == CHAR_DOT) begin
                  v4_phase = PH_PRE;
                  v4_index = v4_index + 3'd1;
               end else if (c != CHAR_SPACE) begin
                  v4_phase = PH_FAIL;
               end
            end
            PH_TAIL: begin
               if (c != CHAR_SPACE) begin
                  v4_phase = (c == CHAR_COLON) ? PH_OK : PH_FAIL;
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   task automatic step_hex(input logic [7:0] c);
      logic [4:0] nib;
      nib = nibble_of(c);
      if (v6_phase == PH_NUM && nib[4]) begin
         if (v6_ndigits >= 3'd4) begin
            v6_phase = PH_FAIL;
         end else begin
            v6_ndigits = v6_ndigits + 3'd1;
            v6_group   = {v6_group[11:0], nib[3:0]};
         end
      end else begin
         if (v6_phase == PH_NUM) begin
            close_hex_quartet();
         end
         case (v6_phase)
            PH_PRE: begin
               if (c == CHAR_LBRACK && !saw_text) begin
                  in_brackets = 1'b1;
               end else if (nib[4]) begin
                  v6_phase   = PH_NUM;
                  v6_ndigits = 3'd1;
                  v6_group   = {12'h000, nib[3:0]};
               end else if (c != CHAR_SPACE) begin
                  v6_phase = PH_FAIL;
               end
            end
            PH_POST: begin
               if (c == CHAR_COLON) begin
                  v6_phase = PH_PRE;
                  v6_index = v6_index + 3'd1;
               end else if (c != CHAR_SPACE) begin
                  v6_phase = PH_FAIL;
               end
            end
            PH_TAIL: begin
               if (c != CHAR_SPACE) begin
                  v6_phase = (c == CHAR_RBRACK && in_brackets) ? PH_OK : PH_FAIL;
               end
            end
            default: begin
            end
         endcase
      end
   endtask

   task automatic take_char(input req_item_type it);
      rsp_item_type addr;
      step_dotted(it.ch);
      step_hex(it.ch);
      if (it.ch == CHAR_DOT) saw_dot = 1'b1;
      if (it.ch == CHAR_COLON) saw_colon = 1'b1;
      if (it.ch != CHAR_SPACE) saw_text = 1'b1;
      if (it.last) begin
         if (v4_phase == PH_NUM) close_dotted_byte();
         if (v6_phase == PH_NUM) close_hex_quartet();
         addr = '0;
         if (saw_dot) begin
            if (v4_phase == PH_OK || v4_phase == PH_TAIL) begin
               addr.valid_res = 1'b1;
               addr.is_ipv4   = 1'b1;
               addr.addr_low  = {V4_MAPPED, v4_word};
            end
         end else if (saw_colon && (v6_phase == PH_OK || v6_phase == PH_TAIL)) begin
            addr.valid_res = 1'b1;
            addr.addr_high = {v6_groups[0], v6_groups[1], v6_groups[2], v6_groups[3]};
            addr.addr_low  = {v6_groups[4], v6_groups[5], v6_groups[6], v6_groups[7]};
         end
         expected_addrs.push_back(addr);
         clear_parsers();
      end
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_buf.push_back(s[i]);
      end
   endtask

   task automatic add_spaces();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) text_buf.push_back(CHAR_SPACE);
      end
   endtask

   task automatic send_text();
      req_item_type it;
      foreach (text_buf[i]) begin
         it.ch   = text_buf[i];
         it.last = (i == text_buf.size() - 1);
         pending_chars.push_back(it);
      end
      text_buf.delete();
   endtask

   task automatic build_dotted();
      int value;
      for (int i = 0; i < 4; i++) begin
         add_spaces();
         case ($urandom_range(0, 9))
            0: value = 0;
            1: value = 255;
            2: value = $urandom_range(256, 999);
            default: value = $urandom_range(0, 255);
         endcase
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 2)) text_buf.push_back(CHAR_ZERO);
         end
         add_text($sformatf("%0d", value));
         add_spaces();
         if (i < 3) text_buf.push_back(CHAR_DOT);
      end
      if ($urandom_range(0, 2) == 0) begin
         text_buf.push_back(CHAR_COLON);
         add_text($sformatf("%0d", $urandom_range(0, 65535)));
         repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic build_hex();
      int         ndig;
      logic [3:0] nib;
      logic       bracket;
      bracket = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) == 0) text_buf.push_back(CHAR_SPACE);
      if (bracket) text_buf.push_back(CHAR_LBRACK);
      for (int i = 0; i < QUARTETS; i++) begin
         add_spaces();
         ndig = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
         repeat (ndig) begin
            nib = 4'($urandom_range(0, 15));
            if (nib < 4'd10) begin
               text_buf.push_back(CHAR_ZERO + 8'(nib));
            end else if ($urandom_range(0, 1) == 1) begin
               text_buf.push_back(CHAR_UPPER_A + 8'(nib) - 8'd10);
            end else begin
               text_buf.push_back(CHAR_LOWER_A + 8'(nib) - 8'd10);
            end
         end
         add_spaces();
         if (i < QUARTETS - 1) text_buf.push_back(CHAR_COLON);
      end
      if (bracket && $urandom_range(0, 3) != 0) begin
         text_buf.push_back(CHAR_RBRACK);
         repeat ($urandom_range(0, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic mangle_text();
      int         pos;
      logic [7:0] junk;
      case ($urandom_range(0, 7))
         0: junk = CHAR_DOT;
         1: junk = CHAR_COLON;
         2: junk = CHAR_SPACE;
         3: junk = CHAR_LBRACK;
         4: junk = CHAR_RBRACK;
         5: junk = CHAR_NINE;
         6: junk = CHAR_LOWER_G;
         default: junk = 8'($urandom_range(0, 255));
      endcase
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 3))
         0: text_buf[pos] = 8'($urandom_range(0, 255));
         1: if (text_buf.size() > 1) text_buf.delete(pos);
         2: text_buf.insert(pos, junk);
         default: text_buf[pos] = junk;
      endcase
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     <= 0;
         gap_left       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0 || pending_chars.size() == 0) begin
            req_chan.valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_chan.valid <= 1'b1;
            req_chan.item  <= pending_chars.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_mode        <= RX_OPEN;
         rx_left        <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_chan.ready <= 1'b1;
            RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_chan.ready <= (cycle_count % 5 == 0);
            default:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_parsers();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            take_char(req_chan.item);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_addrs.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p",
                        $time, rsp_chan.item);
               mismatches++;
            end else begin
               want_addr = expected_addrs.pop_front();
               report_field("valid_res", 64'(want_addr.valid_res),
                            64'(rsp_chan.item.valid_res));
               report_field("is_ipv4", 64'(want_addr.is_ipv4), 64'(rsp_chan.item.is_ipv4));
               report_field("addr_high", want_addr.addr_high, rsp_chan.item.addr_high);
               report_field("addr_low", want_addr.addr_low, rsp_chan.item.addr_low);
            end
         end
      end
   end

   initial begin
      int chars_made;
      int lines_made;
      chars_made     = 0;
      lines_made     = 0;
      mismatches     = 0;
      cycle_count    = 0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.item  = '0;
      rsp_chan.ready = 1'b0;

      add_text("0.0.0.0");                      send_text();
      add_text("255.255.255.255");              send_text();
      add_text("256.1.2.3");                    send_text();
      add_text("1.2.3.4:8080 x");               send_text();
      add_text("  10 . 20 .30. 40  ");          send_text();
      add_text("001.02.3.4");                   send_text();
      add_text("1.2.3");                        send_text();
      add_text("1.2.3.4.5");                    send_text();
      add_text("1.2.3.4 x");                    send_text();
      add_text("0:0:0:0:0:0:0:0");              send_text();
      add_text("ffff:FFFF:aBcD:0:1:2:3:4");     send_text();
      add_text("[1:2:3:4:5:6:7:8]tail");        send_text();
      add_text(" [ 1 : 2:3:4:5:6:7:8 ] ");      send_text();
      add_text("[1:2:3:4:5:6:7:8");             send_text();
      add_text("1:2:3:4:5:6:7:8]");             send_text();
      add_text("[[1:2:3:4:5:6:7:8]");           send_text();
      add_text("12345:1:2:3:4:5:6:7");          send_text();
      add_text("1::2:3:4:5:6:7");               send_text();
      add_text("1:2:3:4:5:6:7");                send_text();
      add_text("1:2:3:4:5:6:7:8:9");            send_text();
      add_text("1:2:3.4");                      send_text();
      add_text("hello");                        send_text();
      add_text("1.2.3.");
      text_buf.push_back(8'hb4);
      send_text();
      add_text("1:2:3:4:5:6:7:");
      text_buf.push_back(8'he5);
      send_text();

      while (chars_made < RANDOM_CHARS || lines_made < MIN_LINES) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: build_dotted();
            4, 5, 6, 7: build_hex();
            default: repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
         endcase
         if ($urandom_range(0, 3) == 0) mangle_text();
         chars_made += text_buf.size();
         send_text();
         lines_made++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_chan.valid || expected_addrs.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/ipatp_pkg.sv
design/ipatp_if.sv
design/ip_address_text_parser_top.sv
verif/ip_address_text_parser_top_tb.sv
